[rtl/core/utf8_code_point_filter_macros.svh]
// ----------------------------------------------------------------------------
// utf8 code point filter assertion macros
// shared property forms for the filter's checks, clocked on clk_i and
// disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef UTF8_CODE_POINT_FILTER_MACROS_SVH
`define UTF8_CODE_POINT_FILTER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define UCPF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define UCPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/utf8cpf_pkg.sv]
// ----------------------------------------------------------------------------
// utf8 code point filter package
// shared types, constants and decode helpers of the filter
// ----------------------------------------------------------------------------
package utf8cpf_pkg;

  // code point width
  localparam int unsigned CpW = 21;

  // queue between classifier and byte emitter
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // configuration register indexes
  localparam logic [1:0] CfgDropA = 2'd0;
  localparam logic [1:0] CfgDropB = 2'd1;
  localparam logic [1:0] CfgDropC = 2'd2;

  // reset values of the drop registers
  localparam logic [CpW-1:0] DropAReset = CpW'(32'h02C8);
  localparam logic [CpW-1:0] DropBReset = CpW'(32'h02CC);
  localparam logic [CpW-1:0] DropCReset = CpW'(32'h005F);

  // drop code registers as seen by the classifier
  typedef struct packed {
    logic [CpW-1:0] code_a;
    logic [CpW-1:0] code_b;
    logic [CpW-1:0] code_c;
  } drop_codes_t;

  // one queued group of bytes to copy out
  typedef struct packed {
    logic [3:0][7:0] bytes;    // bytes in stream order
    logic [2:0]      cnt;      // number of bytes to copy, 0 to 4
    logic            str_end;  // input byte closed the string
  } entry_t;

  // continuation byte 10xxxxxx
  function automatic logic is_cont(logic [7:0] b);
    return (b & 8'hC0) == 8'h80;
  endfunction

  // sequence length by lead byte, 0 for an invalid lead
  function automatic logic [2:0] seq_len(logic [7:0] lead);
    logic [2:0] len;
    if (lead < 8'h80) begin
      len = 3'd1;
    end else if ((lead & 8'hE0) == 8'hC0) begin
      len = 3'd2;
    end else if ((lead & 8'hF0) == 8'hE0) begin
      len = 3'd3;
    end else if ((lead & 8'hF8) == 8'hF0) begin
      len = 3'd4;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

  // code point of a sequence of the given length
  function automatic logic [CpW-1:0] decode(logic [3:0][7:0] s, logic [2:0] len);
    logic [CpW-1:0] cp;
    unique case (len)
      3'd2:    cp = {10'b0, s[0][4:0], s[1][5:0]};
      3'd3:    cp = {5'b0, s[0][3:0], s[1][5:0], s[2][5:0]};
      3'd4:    cp = {s[0][2:0], s[1][5:0], s[2][5:0], s[3][5:0]};
      default: cp = {13'b0, s[0]};
    endcase
    return cp;
  endfunction

  // code point matches one of the drop registers
  function automatic logic is_drop(logic [CpW-1:0] cp, drop_codes_t codes);
    return (cp == codes.code_a) || (cp == codes.code_b) || (cp == codes.code_c);
  endfunction

endpackage

[rtl/core/utf8cpf_front.sv]
// ----------------------------------------------------------------------------
// utf8 code point filter classifier
// takes one byte per cycle while the queue is not full, tracks the open
// sequence and queues the bytes that each input releases for copying
// ----------------------------------------------------------------------------
`include "utf8_code_point_filter_macros.svh"

module utf8cpf_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_tvalid_i,
  output logic                      s_tready_o,
  input  logic [7:0]                s_tdata_i,   // in_byte
  input  logic                      s_tlast_i,   // in_end
  input  utf8cpf_pkg::drop_codes_t  codes_i,
  input  logic                      full_i,
  output logic                      push_o,
  output utf8cpf_pkg::entry_t       entry_o
);

  logic [7:0]                   held_q [3];
  logic [1:0]                   held_cnt_q, held_cnt_d;
  logic [2:0]                   hc_ext;
  logic [2:0]                   hlen;
  logic [2:0]                   b_len;
  logic                         b_cont;
  logic [3:0][7:0]              seq;
  logic [utf8cpf_pkg::CpW-1:0]  cp_multi;
  logic [2:0]                   emit_cnt;
  logic                         hold_b;
  logic [1:0]                   hold_idx;
  logic                         accept;

  assign s_tready_o = !full_i;
  assign accept     = s_tvalid_i && s_tready_o;

  // held bytes followed by the new byte
  always_comb begin
    seq[0] = (held_cnt_q > 2'd0) ? held_q[0] : s_tdata_i;
    seq[1] = (held_cnt_q > 2'd1) ? held_q[1] : s_tdata_i;
    seq[2] = (held_cnt_q > 2'd2) ? held_q[2] : s_tdata_i;
    seq[3] = s_tdata_i;
  end

  assign hc_ext   = {1'b0, held_cnt_q};
  assign hlen     = utf8cpf_pkg::seq_len(held_q[0]);
  assign b_len    = utf8cpf_pkg::seq_len(s_tdata_i);
  assign b_cont   = utf8cpf_pkg::is_cont(s_tdata_i);
  assign cp_multi = utf8cpf_pkg::decode(seq, hlen);

  // classify the byte against the open sequence
  always_comb begin
    emit_cnt   = 3'd0;
    held_cnt_d = held_cnt_q;
    hold_b     = 1'b0;
    hold_idx   = held_cnt_q;
    if (held_cnt_q != 2'd0 && b_cont) begin
      if (hc_ext + 3'd1 == hlen) begin
        // sequence complete
        emit_cnt   = utf8cpf_pkg::is_drop(cp_multi, codes_i) ? 3'd0 : hc_ext + 3'd1;
        held_cnt_d = 2'd0;
      end else if (s_tlast_i) begin
        // string ends inside the sequence, everything goes out as invalid
        emit_cnt   = hc_ext + 3'd1;
        held_cnt_d = 2'd0;
      end else begin
        hold_b     = 1'b1;
        hold_idx   = held_cnt_q;
        held_cnt_d = held_cnt_q + 2'd1;
      end
    end else begin
      // held bytes (if any) fail, new byte starts fresh
      case (b_len)
        3'd1: begin
          emit_cnt   = utf8cpf_pkg::is_drop({13'b0, s_tdata_i}, codes_i) ? hc_ext
                                                                          : hc_ext + 3'd1;
          held_cnt_d = 2'd0;
        end
        3'd0: begin
          emit_cnt   = hc_ext + 3'd1;
          held_cnt_d = 2'd0;
        end
        default: begin
          if (s_tlast_i) begin
            emit_cnt   = hc_ext + 3'd1;
            held_cnt_d = 2'd0;
          end else begin
            emit_cnt   = hc_ext;
            hold_b     = 1'b1;
            hold_idx   = 2'd0;
            held_cnt_d = 2'd1;
          end
        end
      endcase
    end
  end

  // queue write
  assign push_o          = accept && (emit_cnt != 3'd0 || s_tlast_i);
  assign entry_o.bytes   = seq;
  assign entry_o.cnt     = emit_cnt;
  assign entry_o.str_end = s_tlast_i;

  // held count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt_q <= 2'd0;
    end else if (accept) begin
      held_cnt_q <= held_cnt_d;
    end
  end

  // held bytes
  always_ff @(posedge clk_i) begin
    if (accept && hold_b) begin
      held_q[hold_idx] <= s_tdata_i;
    end
  end

  `UCPF_ASSERT_NOW(a_held_open, held_cnt_q != 2'd0, hc_ext < hlen, "held sequence not open")
  `UCPF_ASSERT_NEXT(a_end_flush, accept && s_tlast_i, held_cnt_q == 2'd0, "bytes held after end")

endmodule

[rtl/core/utf8cpf_fifo.sv]
// ----------------------------------------------------------------------------
// utf8 code point filter queue
// short queue of byte groups between classifier and byte emitter
// ----------------------------------------------------------------------------
module utf8cpf_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  utf8cpf_pkg::entry_t  entry_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output utf8cpf_pkg::entry_t  head_o
);

  utf8cpf_pkg::entry_t                  mem_q [utf8cpf_pkg::FifoDepth];
  logic [utf8cpf_pkg::FifoPtrW-1:0]     wr_ptr_q;
  logic [utf8cpf_pkg::FifoPtrW-1:0]     rd_ptr_q;
  logic [utf8cpf_pkg::FifoCntW-1:0]     cnt_q;

  assign full_o  = cnt_q == utf8cpf_pkg::FifoCntW'(utf8cpf_pkg::FifoDepth);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + utf8cpf_pkg::FifoPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + utf8cpf_pkg::FifoPtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + utf8cpf_pkg::FifoCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - utf8cpf_pkg::FifoCntW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

[rtl/core/utf8cpf_back.sv]
// ----------------------------------------------------------------------------
// utf8 code point filter byte emitter
// walks the queued byte groups one byte per transfer into the output register
// ----------------------------------------------------------------------------
`include "utf8_code_point_filter_macros.svh"

module utf8cpf_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  utf8cpf_pkg::entry_t  head_i,
  output logic                 pop_o,
  output logic                 m_tvalid_o,
  input  logic                 m_tready_i,
  output logic [7:0]           m_tdata_o,   // out_byte
  output logic                 m_tlast_o,   // run_last
  output logic [1:0]           m_tuser_o    // byte_valid, string_end
);

  logic       m_valid_q;
  logic [7:0] data_q;
  logic       bvalid_q;
  logic       last_q;
  logic       send_q;
  logic [1:0] idx_q;
  logic       out_free;
  logic       take;
  logic       last;

  assign out_free = !m_valid_q || m_tready_i;
  assign take     = out_free && !empty_i;
  assign last     = (head_i.cnt == 3'd0) || ({1'b0, idx_q} + 3'd1 == head_i.cnt);
  assign pop_o    = take && last;

  // output valid and position in the head group
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      idx_q     <= 2'd0;
    end else begin
      if (out_free) begin
        m_valid_q <= !empty_i;
      end
      if (take) begin
        idx_q <= last ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q   <= (head_i.cnt == 3'd0) ? 8'h00 : head_i.bytes[idx_q];
      bvalid_q <= head_i.cnt != 3'd0;
      last_q   <= last;
      send_q   <= head_i.str_end && last;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = data_q;
  assign m_tlast_o  = last_q;
  assign m_tuser_o  = {send_q, bvalid_q};

  `UCPF_ASSERT_NOW(a_bare_end, m_valid_q && !bvalid_q, last_q && send_q, "bare marker not final")
  `UCPF_ASSERT_NOW(a_idx_range, !empty_i && head_i.cnt != 3'd0, {1'b0, idx_q} < head_i.cnt, "byte index past group")
  `UCPF_ASSERT_NEXT(a_pop_rewind, pop_o, idx_q == 2'd0, "index not rewound after group")

endmodule

[rtl/core/utf8_code_point_filter.sv]
// ----------------------------------------------------------------------------
// utf8 code point filter
// decodes a utf-8 byte stream and copies it through, removing characters
// whose code point matches one of three drop registers
// ----------------------------------------------------------------------------
// The filter accepts one byte per cycle on the input stream while the queue is
// not full and writes, for each byte, the group of bytes it releases (0 to 4,
// or one bare end marker) into a 4-entry queue; the emitter drains that queue
// one byte per cycle through a registered output while the receiver is ready,
// so the queue absorbs the bursts. An input byte reaches the output through
// the queue entry and the output register. The drop registers should
// only be written while the stream is idle.

module utf8_code_point_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  input  logic [7:0]                    s_tdata_i,    // in_byte
  input  logic                          s_tlast_i,    // in_end
  // output stream
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [7:0]                    m_tdata_o,    // out_byte
  output logic                          m_tlast_o,    // run_last
  output logic [1:0]                    m_tuser_o,    // [0] byte_valid, [1] string_end
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [utf8cpf_pkg::CpW-1:0]   cfg_data_i
);

  utf8cpf_pkg::drop_codes_t  codes_q;
  utf8cpf_pkg::entry_t       push_entry;
  utf8cpf_pkg::entry_t       head;
  logic                      push;
  logic                      pop;
  logic                      full;
  logic                      empty;

  assign cfg_ready_o = 1'b1;

  // drop code registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q.code_a <= utf8cpf_pkg::DropAReset;
      codes_q.code_b <= utf8cpf_pkg::DropBReset;
      codes_q.code_c <= utf8cpf_pkg::DropCReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        utf8cpf_pkg::CfgDropA: codes_q.code_a <= cfg_data_i;
        utf8cpf_pkg::CfgDropB: codes_q.code_b <= cfg_data_i;
        utf8cpf_pkg::CfgDropC: codes_q.code_c <= cfg_data_i;
        default: ;
      endcase
    end
  end

  utf8cpf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tlast_i  (s_tlast_i),
    .codes_i    (codes_q),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  utf8cpf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  utf8cpf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .head_i     (head),
    .pop_o      (pop),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o),
    .m_tuser_o  (m_tuser_o)
  );

endmodule

[sim/tb_utf8_code_point_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8 code point filter testbench
// streams utf-8 bytes into the filter, predicts the copied bytes and end
// markers for every input transfer and compares each output transfer with
// the oldest prediction; directed cases first, then random text under three
// backpressure profiles and several drop register settings
// ----------------------------------------------------------------------------

module tb_utf8_code_point_filter;

  localparam int unsigned StallLimit  = 5000;
  localparam int unsigned DrainCycles = 8;

  // one output transfer as predicted
  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       run_last;
    logic       string_end;
  } out_item_t;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           s_tvalid_i  = 1'b0;
  logic                           s_tready_o;
  logic [7:0]                     s_tdata_i   = 8'h00;
  logic                           s_tlast_i   = 1'b0;
  logic                           m_tvalid_o;
  logic                           m_tready_i  = 1'b0;
  logic [7:0]                     m_tdata_o;
  logic                           m_tlast_o;
  logic [1:0]                     m_tuser_o;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [1:0]                     cfg_index_i = utf8cpf_pkg::CfgDropA;
  logic [utf8cpf_pkg::CpW-1:0]    cfg_data_i  = '0;

  // predictor state: drop codes by register index and the open sequence
  logic [utf8cpf_pkg::CpW-1:0] drop_code [3];
  logic [7:0]                  open_seq_bytes [3];
  int unsigned                 open_seq_cnt = 0;

  out_item_t   filtered_bytes_q [$];
  out_item_t   got_item, want_item;
  int unsigned error_cnt     = 0;
  int unsigned stall_cycles  = 0;
  int unsigned bytes_sent    = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  utf8_code_point_filter u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tlast_i   (s_tlast_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tlast_o   (m_tlast_o),
    .m_tuser_o   (m_tuser_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // sequence length from the lead byte, 0 for a byte that cannot lead
  function automatic int unsigned lead_length(input logic [7:0] lead);
    if (lead[7] == 1'b0) return 1;
    if (lead[7:5] == 3'b110) return 2;
    if (lead[7:4] == 4'b1110) return 3;
    if (lead[7:3] == 5'b11110) return 4;
    return 0;
  endfunction

  // expected output transfers for one accepted input byte
  function automatic void filter_next_byte(input logic [7:0] in_b, input logic in_e);
    logic [7:0]  win [4];
    out_item_t   outs [$];
    int unsigned n, pos, len, avail, chk, i;
    logic        ok;
    logic [31:0] cp;
    n = open_seq_cnt;
    for (i = 0; i < n; i++) win[i] = open_seq_bytes[i];
    win[n] = in_b;
    n++;
    pos = 0;
    while (pos < n) begin
      len = lead_length(win[pos]);
      avail = n - pos;
      // a byte that cannot lead is copied as invalid
      if (len == 0) begin
        outs.insert(outs.size(), out_item_t'{win[pos], 1'b1, 1'b0, 1'b0});
        pos++;
        continue;
      end
      chk = (len < avail) ? len : avail;
      ok = 1'b1;
      for (i = 1; i < chk; i++) begin
        if (win[pos+i][7:6] != 2'b10) ok = 1'b0;
      end
      // broken sequence, or cut short by the end of the string
      if (!ok || (avail < len && in_e)) begin
        outs.insert(outs.size(), out_item_t'{win[pos], 1'b1, 1'b0, 1'b0});
        pos++;
        continue;
      end
      if (avail < len) break;
      // complete character: copy unless its code point is dropped
      case (len)
        1:       cp = {24'b0, win[pos]};
        2:       cp = {27'b0, win[pos][4:0]};
        3:       cp = {28'b0, win[pos][3:0]};
        default: cp = {29'b0, win[pos][2:0]};
      endcase
      for (i = 1; i < len; i++) cp = {cp[25:0], win[pos+i][5:0]};
      if (cp[utf8cpf_pkg::CpW-1:0] != drop_code[0] &&
          cp[utf8cpf_pkg::CpW-1:0] != drop_code[1] &&
          cp[utf8cpf_pkg::CpW-1:0] != drop_code[2]) begin
        for (i = 0; i < len; i++)
          outs.insert(outs.size(), out_item_t'{win[pos+i], 1'b1, 1'b0, 1'b0});
      end
      pos += len;
    end
    // whatever is left stays open unless the string ends here
    open_seq_cnt = 0;
    if (!in_e) begin
      for (i = pos; i < n && open_seq_cnt < 3; i++) begin
        open_seq_bytes[open_seq_cnt] = win[i];
        open_seq_cnt++;
      end
    end
    if (in_e && outs.size() == 0)
      outs.insert(outs.size(), out_item_t'{8'h00, 1'b0, 1'b0, 1'b0});
    if (outs.size() > 0) begin
      outs[outs.size()-1].run_last = 1'b1;
      outs[outs.size()-1].string_end = in_e;
    end
    foreach (outs[j]) filtered_bytes_q.insert(filtered_bytes_q.size(), outs[j]);
  endfunction

  // one input transfer, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] data, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= data;
    s_tlast_i  <= last;
    do @(posedge clk_i); while (!s_tready_o);
    filter_next_byte(data, last);
    bytes_sent++;
  endtask

  // first nsend bytes of a sequence, end flag on the final one
  task automatic send_seq(input logic [3:0][7:0] s, input int unsigned nsend,
                          input logic last);
    for (int unsigned i = 0; i < nsend; i++) send_byte(s[i], last && (i == nsend - 1));
  endtask

  // shortest utf-8 form of a code point
  task automatic send_code_point(input logic [utf8cpf_pkg::CpW-1:0] cp, input logic last);
    logic [3:0][7:0] s;
    int unsigned     len;
    s = '0;
    if (cp < 'h80) begin
      s[0] = cp[7:0];
      len = 1;
    end else if (cp < 'h800) begin
      s[0] = {3'b110, cp[10:6]};
      s[1] = {2'b10, cp[5:0]};
      len = 2;
    end else if (cp < 'h10000) begin
      s[0] = {4'b1110, cp[15:12]};
      s[1] = {2'b10, cp[11:6]};
      s[2] = {2'b10, cp[5:0]};
      len = 3;
    end else begin
      s[0] = {5'b11110, cp[20:18]};
      s[1] = {2'b10, cp[17:12]};
      s[2] = {2'b10, cp[11:6]};
      s[3] = {2'b10, cp[5:0]};
      len = 4;
    end
    send_seq(s, len, last);
  endtask

  // stop sending and wait until every predicted transfer has arrived
  task automatic drain_stream();
    s_tvalid_i <= 1'b0;
    while (filtered_bytes_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // write all three drop registers; only called with the stream drained
  task automatic write_drop_codes(input logic [utf8cpf_pkg::CpW-1:0] code_a,
                                  input logic [utf8cpf_pkg::CpW-1:0] code_b,
                                  input logic [utf8cpf_pkg::CpW-1:0] code_c);
    logic [1:0]                  idx  [3];
    logic [utf8cpf_pkg::CpW-1:0] vals [3];
    idx  = '{utf8cpf_pkg::CfgDropA, utf8cpf_pkg::CfgDropB, utf8cpf_pkg::CfgDropC};
    vals = '{code_a, code_b, code_c};
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      drop_code[idx[i]] = vals[i];
    end
    cfg_valid_i <= 1'b0;
  endtask

  // reset drop codes: plain, multi-byte, dropped and malformed text
  task automatic test_default_drops();
    send_byte(8'h41, 1'b0);
    send_byte(8'h00, 1'b0);
    send_code_point(21'h0000E9, 1'b0);
    send_code_point(21'h0020AC, 1'b0);
    send_code_point(21'h01F600, 1'b0);
    send_code_point(utf8cpf_pkg::DropAReset, 1'b0);
    send_code_point(utf8cpf_pkg::DropBReset, 1'b0);
    // dropped character closing the string leaves a bare end marker
    send_code_point(utf8cpf_pkg::DropCReset, 1'b1);
    // bytes that cannot lead
    send_byte(8'h80, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hF8, 1'b0);
    send_byte(8'hFF, 1'b0);
    // missing continuation, two and four byte leads
    send_byte(8'hC3, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'h7F, 1'b0);
    // overlong zero and a surrogate decode plainly
    send_byte(8'hC0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hED, 1'b0);
    send_byte(8'hA0, 1'b0);
    send_byte(8'h80, 1'b0);
    // string ends inside a sequence
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
  endtask

  // drop codes at zero, all ones and a plain ascii letter
  task automatic test_drop_extremes();
    drain_stream();
    write_drop_codes('0, '1, 21'h41);
    send_byte(8'h00, 1'b0);
    send_code_point('1, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    // overlong forms of dropped code points are dropped too
    send_byte(8'hC0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hC1, 1'b0);
    send_byte(8'h81, 1'b1);
  endtask

  // random text: mostly well formed, some dropped, broken and noise bytes
  task automatic test_random_stream(input int unsigned n_bytes);
    logic [3:0][7:0] s;
    int unsigned     target, kind, len;
    logic            last, paused;
    target = bytes_sent + n_bytes;
    paused = 1'b0;
    while (bytes_sent < target) begin
      kind = $urandom_range(99);
      last = ($urandom_range(99) < 8);
      len  = $urandom_range(4, 1);
      s[0] = (len == 1) ? 8'($urandom_range(127)) :
             (len == 2) ? (8'hC0 | 8'($urandom_range(31))) :
             (len == 3) ? (8'hE0 | 8'($urandom_range(15))) :
                          (8'hF0 | 8'($urandom_range(7)));
      for (int i = 1; i < 4; i++) s[i] = 8'h80 | 8'($urandom_range(63));
      if (kind < 15) begin
        send_byte(8'($urandom_range(255)), last);
      end else if (kind < 25 && len > 1) begin
        send_seq(s, $urandom_range(len - 1, 1), last);
      end else if (kind < 40) begin
        send_code_point(drop_code[$urandom_range(2)], last);
      end else begin
        send_seq(s, len, last);
      end
      // hold off once until the output has caught up
      if (!paused && bytes_sent >= target - n_bytes / 2) begin
        drain_stream();
        paused = 1'b1;
      end
    end
    send_byte(8'($urandom_range(127)), 1'b1);
  endtask

  // output side: random ready and result checking
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      got_item = '{m_tdata_o, m_tuser_o[0], m_tlast_o, m_tuser_o[1]};
      if (filtered_bytes_q.size() == 0) begin
        error_cnt++;
        if (error_cnt <= 10)
          $display("[%0t] unexpected transfer: data %h valid %b last %b end %b", $time,
                   got_item.data, got_item.byte_valid, got_item.run_last,
                   got_item.string_end);
      end else begin
        want_item = filtered_bytes_q.pop_front();
        if (got_item !== want_item) begin
          error_cnt++;
          if (error_cnt <= 10)
            $display("[%0t] mismatch: exp %h/%b/%b/%b got %h/%b/%b/%b",
                     $time, want_item.data, want_item.byte_valid, want_item.run_last,
                     want_item.string_end, got_item.data, got_item.byte_valid,
                     got_item.run_last, got_item.string_end);
        end
      end
    end
    m_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= StallLimit) begin
      $display("[%0t] no transfer for %0d cycles", $time, stall_cycles);
      $display("utf8_code_point_filter test failed");
      $finish;
    end
  end

  initial begin
    drop_code[utf8cpf_pkg::CfgDropA] = utf8cpf_pkg::DropAReset;
    drop_code[utf8cpf_pkg::CfgDropB] = utf8cpf_pkg::DropBReset;
    drop_code[utf8cpf_pkg::CfgDropC] = utf8cpf_pkg::DropCReset;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender idles little, receiver a lot
    send_idle_pct = 16;
    recv_idle_pct = 87;
    test_default_drops();
    test_drop_extremes();
    test_random_stream(55);

    // sender idles a lot, receiver little
    send_idle_pct = 87;
    recv_idle_pct = 16;
    drain_stream();
    write_drop_codes(utf8cpf_pkg::CpW'($urandom_range('h7FF, 'h80)),
                     utf8cpf_pkg::CpW'($urandom_range('hFFFF, 'h800)),
                     utf8cpf_pkg::CpW'($urandom_range('h1FFFFF, 'h10000)));
    test_random_stream(55);

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain_stream();
    write_drop_codes(utf8cpf_pkg::DropAReset, utf8cpf_pkg::DropBReset,
                     utf8cpf_pkg::CpW'($urandom_range(127)));
    test_random_stream(55);

    drain_stream();
    if (filtered_bytes_q.size() != 0)
      $display("%0d predicted transfers never arrived", filtered_bytes_q.size());
    if (error_cnt == 0 && filtered_bytes_q.size() == 0) begin
      $display("utf8_code_point_filter test passed");
    end else begin
      $display("utf8_code_point_filter test failed");
    end
    $finish;
  end

endmodule
